// ===== rtl/core/variable_path_parser_core_defines.svh =====
// assertion macros for the variable path parser core
`ifndef VARIABLE_PATH_PARSER_CORE_DEFINES_SVH
`define VARIABLE_PATH_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
// checked while out of reset
`define VPP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("vpp assertion failed");
// checked at every edge, reset included
`define VPP_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("vpp reset assertion failed");
`else
`define VPP_ASSERT(lbl, prop)
`define VPP_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== rtl/core/vpp_pkg.sv =====
package vpp_pkg;

    localparam int CHAR_W    = 21;
    localparam int ERR_POS_W = 16;

    localparam logic [CHAR_W-1:0] CH_OPEN  = 21'h00005B;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 21'h00005D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 21'h00002E;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 21'h000022;
    localparam logic [CHAR_W-1:0] CH_BSL   = 21'h00005C;

    localparam logic [1:0] ROLE_NONE  = 2'd0;
    localparam logic [1:0] ROLE_ROOT  = 2'd1;
    localparam logic [1:0] ROLE_CHILD = 2'd2;
    localparam logic [1:0] ROLE_SUB   = 2'd3;

    localparam logic [1:0] CLOSE_NONE  = 2'd0;
    localparam logic [1:0] CLOSE_ROOT  = 2'd1;
    localparam logic [1:0] CLOSE_CHILD = 2'd2;
    localparam logic [1:0] CLOSE_SUB   = 2'd3;

    localparam logic [1:0] ST_PARSING     = 2'd0;
    localparam logic [1:0] ST_OK          = 2'd1;
    localparam logic [1:0] ST_ERR_NAME    = 2'd2;
    localparam logic [1:0] ST_ERR_BRACKET = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              end_of_expression;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]    char_echo;
        logic [1:0]           role;
        logic [1:0]           closes;
        logic [1:0]           status;
        logic [ERR_POS_W-1:0] error_position;
    } out_item_t;

endpackage

// ===== rtl/core/vpp_parse.sv =====
module vpp_parse
    import vpp_pkg::*;
#(
    parameter int NEST_BITS     = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result
);

    typedef enum logic [2:0] {
        MODE_EXP_NAME,
        MODE_IN_NAME,
        MODE_AFTER,
        MODE_SUBSCRIPT,
        MODE_DONE
    } mode_t;

    mode_t                    mode_reg, mode_next;
    logic                     root_seen_reg, root_seen_next;
    logic                     literal_reg, literal_next;
    logic                     bsl_reg, bsl_next;
    logic [NEST_BITS-1:0]     depth_reg, depth_next;
    logic [POSITION_BITS-1:0] count_reg, count_next, count_inc;
    logic [1:0]               status_reg, status_next;
    logic [POSITION_BITS-1:0] err_pos_reg, err_pos_next;
    out_item_t                result_reg, result_next;

    logic                     is_delim;
    logic                     do_after;
    logic [1:0]               role;
    logic [1:0]               closes;
    logic [1:0]               name_role;
    logic [1:0]               name_close;
    logic [CHAR_W-1:0]        c;

    always_comb begin
        c              = item.character;
        mode_next      = mode_reg;
        root_seen_next = root_seen_reg;
        literal_next   = literal_reg;
        bsl_next       = bsl_reg;
        depth_next     = depth_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        err_pos_next   = err_pos_reg;
        role           = ROLE_NONE;
        closes         = CLOSE_NONE;
        do_after       = 1'b0;
        is_delim       = (c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_DOT);
        name_role      = root_seen_reg ? ROLE_CHILD : ROLE_ROOT;
        name_close     = root_seen_reg ? CLOSE_CHILD : CLOSE_ROOT;
        count_inc      = (count_reg == {POSITION_BITS{1'b1}}) ? count_reg
                       : count_reg + POSITION_BITS'(1);

        if (item.end_of_expression) begin
            unique case (mode_reg)
                MODE_EXP_NAME: begin
                    status_next  = ST_ERR_NAME;
                    err_pos_next = count_reg;
                    mode_next    = MODE_DONE;
                end
                MODE_IN_NAME: begin
                    closes         = name_close;
                    root_seen_next = 1'b1;
                    status_next    = ST_OK;
                end
                MODE_AFTER: begin
                    status_next = ST_OK;
                end
                MODE_SUBSCRIPT: begin
                    status_next  = ST_ERR_BRACKET;
                    err_pos_next = count_reg;
                    mode_next    = MODE_DONE;
                end
                default: begin
                end
            endcase
        end else begin
            unique case (mode_reg)
                MODE_EXP_NAME: begin
                    count_next = count_inc;
                    if (is_delim) begin
                        status_next  = ST_ERR_NAME;
                        err_pos_next = count_inc;
                        mode_next    = MODE_DONE;
                    end else begin
                        role      = name_role;
                        mode_next = MODE_IN_NAME;
                    end
                end
                MODE_IN_NAME: begin
                    if (is_delim) begin
                        closes         = name_close;
                        root_seen_next = 1'b1;
                        do_after       = 1'b1;
                    end else begin
                        role       = name_role;
                        count_next = count_inc;
                    end
                end
                MODE_AFTER: begin
                    do_after = 1'b1;
                end
                MODE_SUBSCRIPT: begin
                    count_next = count_inc;
                    if (c == CH_CLOSE && !literal_reg && depth_reg == '0) begin
                        closes    = CLOSE_SUB;
                        mode_next = MODE_AFTER;
                    end else begin
                        if (c == CH_QUOTE) begin
                            if (!literal_reg) begin
                                literal_next = 1'b1;
                            end else if (!bsl_reg) begin
                                literal_next = 1'b0;
                            end
                        end else if (c == CH_OPEN && !literal_reg) begin
                            if (depth_reg != {NEST_BITS{1'b1}}) begin
                                depth_next = depth_reg + NEST_BITS'(1);
                            end
                        end else if (c == CH_CLOSE && !literal_reg) begin
                            depth_next = depth_reg - NEST_BITS'(1);
                        end
                        bsl_next = (c == CH_BSL);
                        role     = ROLE_SUB;
                    end
                end
                default: begin
                end
            endcase

            // delimiter that follows a finished item
            if (do_after) begin
                if (c == CH_DOT) begin
                    count_next = count_inc;
                    mode_next  = MODE_EXP_NAME;
                end else if (c == CH_OPEN) begin
                    count_next   = count_inc;
                    literal_next = 1'b0;
                    bsl_next     = 1'b0;
                    depth_next   = '0;
                    mode_next    = MODE_SUBSCRIPT;
                end else begin
                    status_next = ST_OK;
                    mode_next   = MODE_DONE;
                end
            end
        end

        result_next.char_echo      = item.end_of_expression ? '0 : c;
        result_next.role           = role;
        result_next.closes         = closes;
        result_next.status         = status_next;
        result_next.error_position = status_next[1] ? ERR_POS_W'(err_pos_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_EXP_NAME;
            root_seen_reg <= 1'b0;
            literal_reg   <= 1'b0;
            bsl_reg       <= 1'b0;
            depth_reg     <= '0;
            count_reg     <= '0;
            status_reg    <= ST_PARSING;
            err_pos_reg   <= '0;
        end else if (step) begin
            result_reg <= result_next;
            if (item.end_of_expression) begin
                mode_reg      <= MODE_EXP_NAME;
                root_seen_reg <= 1'b0;
                literal_reg   <= 1'b0;
                bsl_reg       <= 1'b0;
                depth_reg     <= '0;
                count_reg     <= '0;
                status_reg    <= ST_PARSING;
                err_pos_reg   <= '0;
            end else begin
                mode_reg      <= mode_next;
                root_seen_reg <= root_seen_next;
                literal_reg   <= literal_next;
                bsl_reg       <= bsl_next;
                depth_reg     <= depth_next;
                count_reg     <= count_next;
                status_reg    <= status_next;
                err_pos_reg   <= err_pos_next;
            end
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/core/variable_path_parser_core.sv =====
// datapath: each item passes through the input register and then the result register; while
// m_valid is high and m_ready is low, the result register holds and the input register waits
// throughput: one item per cycle while m_ready is high; the parse step is short logic
// between the two registers and the parser state updates once per item
// reset: synchronous active-low aresetn empties both registers and returns the
// parser to expecting a root name with all counters at zero
`include "variable_path_parser_core_defines.svh"

module variable_path_parser_core
    import vpp_pkg::*;
#(
    parameter int NEST_BITS     = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     out_valid_reg;
    logic     advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_item_reg  <= s_data;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    vpp_parse #(
        .NEST_BITS    (NEST_BITS),
        .POSITION_BITS(POSITION_BITS)
    ) u_parse (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (advance),
        .item   (in_item_reg),
        .result (m_data)
    );

    assign m_valid = out_valid_reg;

    `VPP_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid && s_ready)
    `VPP_ASSERT(a_in_hold, in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
    `VPP_ASSERT(a_err_no_role, m_valid && m_data.status[1] |-> m_data.role == ROLE_NONE)
    `VPP_ASSERT(a_pos_zero, m_valid && !m_data.status[1] |-> m_data.error_position == '0)
    `VPP_ASSERT(a_close_no_role, m_valid && m_data.closes != CLOSE_NONE |-> m_data.role == ROLE_NONE)

endmodule
